FILE: sv/gcd_pkg.sv
// gcd_pkg: shared constants, flag type and table function for the great-circle
// distance pipeline. No dependencies; imported by gcd_sincos and great_circle_distance.
`default_nettype none
package gcd_pkg;

    // pi in Q62
    localparam logic [63:0] PI_Q62      = 64'hC90FDAA22168C235;
    // angle span constants in 1e-7 degree
    localparam logic [63:0] DEG_FULL    = 64'd3600000000;
    localparam logic [63:0] DEG_HALF    = 64'd1800000000;
    localparam logic [63:0] DEG_QUARTER = 64'd900000000;
    localparam logic [63:0] DEG_EIGHTH  = 64'd450000000;
    // radians per 1e-7 degree, scaled by 2^93
    localparam logic [63:0] RAD_K93 = ((PI_Q62 / DEG_HALF) << 31)
        + ((((PI_Q62 % DEG_HALF) << 31) + DEG_HALF / 2) / DEG_HALF);

    // reset radius in centimetres (6372795 m)
    localparam logic [30:0] RADIUS_CM_RST = 31'd637279500;

    // octant bookkeeping carried along the sine/cosine pipe
    typedef struct packed {
        logic sneg;
        logic cneg;
        logic swp;
    } sc_flags_t;

    // floor quotient by shift and subtract, for table elaboration
    function automatic logic [63:0] cdiv(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] qt;
        logic [63:0] rm;
        qt = 64'd0;
        rm = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            rm = {rm[62:0], n[b]};
            if (rm >= d) begin
                rm    = rm - d;
                qt[b] = 1'b1;
            end
        end
        return qt;
    endfunction

    // atan(2^-i) in Q62 from the alternating series, terms floored, i >= 1
    function automatic logic [63:0] atan_q62(input int i);
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] term;
        int k;
        pos = 64'd0;
        neg = 64'd0;
        for (k = 0; k < 32; k++) begin
            if (i * (2 * k + 1) <= 62) begin
                term = cdiv(64'd1 << (62 - i * (2 * k + 1)), 64'(2 * k + 1));
                if (k[0])
                    neg = neg + term;
                else
                    pos = pos + term;
            end
        end
        return pos - neg;
    endfunction

endpackage
`default_nettype wire

FILE: sv/gcd_sincos.sv
// gcd_sincos: pipelined sine and cosine of an angle in 1e-7 degree units.
// Octant fold, radian scaling, then Horner Taylor series. Depends on gcd_pkg.
`default_nettype none
module gcd_sincos
    import gcd_pkg::*;
#(
    parameter int FRAC_BITS = 30
)
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    input  wire  signed [32:0]           ang,
    output logic                         out_valid,
    output logic signed [FRAC_BITS+1:0]  sin_v,
    output logic signed [FRAC_BITS+1:0]  cos_v
);

    localparam int Q   = FRAC_BITS;
    localparam int TW  = Q + 1;
    localparam int RW  = Q + 9;
    localparam int PRW = TW + RW;
    localparam logic [TW-1:0] ONE = TW'(1) << Q;

    localparam logic signed [33:0] FULL_S = $signed(34'(DEG_FULL));
    localparam logic signed [33:0] HALF_S = $signed(34'(DEG_HALF));
    localparam logic [32:0] HALF_U    = 33'(DEG_HALF);
    localparam logic [32:0] QUARTER_U = 33'(DEG_QUARTER);
    localparam logic [32:0] EIGHTH_U  = 33'(DEG_EIGHTH);

    // stage 1: wrap into [-180, 180) degrees
    logic signed [33:0] s1_f;
    logic               s1_v_reg;
    logic signed [32:0] s1_r_reg;

    always_comb
    begin
        s1_f = {ang[32], ang};
        if (s1_f >= HALF_S)
            s1_f = s1_f - FULL_S;
        else if (s1_f < -HALF_S)
            s1_f = s1_f + FULL_S;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else
            s1_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        s1_r_reg <= s1_f[32:0];
    end

    // stage 2: fold into [0, 45] degrees
    logic [32:0] s2_m;
    sc_flags_t   s2_fl;
    logic        s2_v_reg;
    logic [28:0] s2_m_reg;
    sc_flags_t   s2_fl_reg;

    always_comb
    begin
        s2_fl.sneg = s1_r_reg[32];
        s2_fl.cneg = 1'b0;
        s2_fl.swp  = 1'b0;
        s2_m = s1_r_reg[32] ? 33'(-s1_r_reg) : 33'(s1_r_reg);
        if (s2_m > QUARTER_U)
        begin
            s2_m = HALF_U - s2_m;
            s2_fl.cneg = 1'b1;
        end
        if (s2_m > EIGHTH_U)
        begin
            s2_m = QUARTER_U - s2_m;
            s2_fl.swp = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else
            s2_v_reg <= s1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_m_reg  <= s2_m[28:0];
        s2_fl_reg <= s2_fl;
    end

    // stage 3: partial products against the radian constant
    logic        s3_v_reg;
    logic [60:0] s3_ph_reg;
    logic [60:0] s3_pl_reg;
    sc_flags_t   s3_fl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_v_reg <= 1'b0;
        else
            s3_v_reg <= s2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_ph_reg <= 61'(s2_m_reg) * 61'(RAD_K93[63:32]);
        s3_pl_reg <= 61'(s2_m_reg) * 61'(RAD_K93[31:0]);
        s3_fl_reg <= s2_fl_reg;
    end

    // stage 4: combine and round to Q radians
    logic [93:0]  s4_sum;
    logic         s4_v_reg;
    logic [Q-1:0] s4_x_reg;
    sc_flags_t    s4_fl_reg;

    assign s4_sum = {1'b0, s3_ph_reg, 32'd0} + 94'(s3_pl_reg) + (94'd1 << (92 - Q));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_v_reg <= 1'b0;
        else
            s4_v_reg <= s3_v_reg;
    end

    always_ff @(posedge clk)
    begin
        s4_x_reg  <= s4_sum[93-Q +: Q];
        s4_fl_reg <= s3_fl_reg;
    end

    // stage 5/6: x squared, rounded
    logic           s5_v_reg;
    logic [2*Q-1:0] s5_xx_reg;
    logic [Q-1:0]   s5_x_reg;
    sc_flags_t      s5_fl_reg;
    logic [2*Q:0]   s6_sum;
    logic           s6_v_reg;
    logic [Q-1:0]   s6_x2_reg;
    logic [Q-1:0]   s6_x_reg;
    sc_flags_t      s6_fl_reg;

    assign s6_sum = {1'b0, s5_xx_reg} + ((2*Q+1)'(1) << (Q - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
        end
        else
        begin
            s5_v_reg <= s4_v_reg;
            s6_v_reg <= s5_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s5_xx_reg <= (2*Q)'(s4_x_reg) * (2*Q)'(s4_x_reg);
        s5_x_reg  <= s4_x_reg;
        s5_fl_reg <= s4_fl_reg;
        s6_x2_reg <= s6_sum[Q +: Q];
        s6_x_reg  <= s5_x_reg;
        s6_fl_reg <= s5_fl_reg;
    end

    // Horner slots: t = 1 - q; product x2*t; q' = (round(x2*t) + d/2) / d
    logic             ha_v_reg  [0:7];
    logic [2*Q:0]     ha_pc_reg [0:7];
    logic [2*Q:0]     ha_ps_reg [0:7];
    logic [Q-1:0]     ha_x2_reg [0:7];
    logic [Q-1:0]     ha_x_reg  [0:7];
    sc_flags_t        ha_fl_reg [0:7];
    logic             hb_v_reg  [0:7];
    logic [PRW-1:0]   hb_pc_reg [0:7];
    logic [PRW-1:0]   hb_ps_reg [0:7];
    logic [Q-1:0]     hb_x2_reg [0:7];
    logic [Q-1:0]     hb_x_reg  [0:7];
    sc_flags_t        hb_fl_reg [0:7];

    for (genvar j = 0; j < 8; j++)
    begin : g_horner
        localparam int KK = 8 - j;
        localparam longint unsigned DC = (2 * KK - 1) * (2 * KK);
        localparam longint unsigned DS = (j == 0) ? 1 : (2 * KK) * (2 * KK + 1);
        localparam longint unsigned RC = ((64'd1 << (Q + 9)) + DC - 1) / DC;
        localparam longint unsigned RS = ((64'd1 << (Q + 9)) + DS - 1) / DS;
        localparam logic [RW-1:0] RC_V = RW'(RC);
        localparam logic [RW-1:0] RS_V = RW'(RS);
        localparam logic [TW-1:0] HC   = TW'(DC / 2);
        localparam logic [TW-1:0] HS   = TW'(DS / 2);

        logic           v_in;
        logic [TW-1:0]  qc_in;
        logic [TW-1:0]  qs_in;
        logic [Q-1:0]   x2_in;
        logic [Q-1:0]   x_in;
        sc_flags_t      fl_in;
        logic [2*Q+1:0] rc_sum;
        logic [2*Q+1:0] rs_sum;
        logic [TW-1:0]  nc;
        logic [TW-1:0]  ns;

        if (j == 0)
        begin : g_first
            assign v_in  = s6_v_reg;
            assign qc_in = '0;
            assign qs_in = '0;
            assign x2_in = s6_x2_reg;
            assign x_in  = s6_x_reg;
            assign fl_in = s6_fl_reg;
        end
        else
        begin : g_next
            assign v_in  = hb_v_reg[j-1];
            assign qc_in = hb_pc_reg[j-1][Q+9 +: TW];
            assign qs_in = hb_ps_reg[j-1][Q+9 +: TW];
            assign x2_in = hb_x2_reg[j-1];
            assign x_in  = hb_x_reg[j-1];
            assign fl_in = hb_fl_reg[j-1];
        end

        assign rc_sum = {1'b0, ha_pc_reg[j]} + ((2*Q+2)'(1) << (Q - 1));
        assign rs_sum = {1'b0, ha_ps_reg[j]} + ((2*Q+2)'(1) << (Q - 1));
        assign nc = rc_sum[Q +: TW] + HC;
        assign ns = rs_sum[Q +: TW] + HS;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ha_v_reg[j] <= 1'b0;
                hb_v_reg[j] <= 1'b0;
            end
            else
            begin
                ha_v_reg[j] <= v_in;
                hb_v_reg[j] <= ha_v_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            ha_pc_reg[j] <= (2*Q+1)'(x2_in) * (2*Q+1)'(ONE - qc_in);
            ha_ps_reg[j] <= (2*Q+1)'(x2_in) * (2*Q+1)'(ONE - qs_in);
            ha_x2_reg[j] <= x2_in;
            ha_x_reg[j]  <= x_in;
            ha_fl_reg[j] <= fl_in;
            hb_pc_reg[j] <= PRW'(nc) * PRW'(RC_V);
            // the sine series is one term shorter: hold it at one in the first slot
            hb_ps_reg[j] <= (j == 0) ? '0 : PRW'(ns) * PRW'(RS_V);
            hb_x2_reg[j] <= ha_x2_reg[j];
            hb_x_reg[j]  <= ha_x_reg[j];
            hb_fl_reg[j] <= ha_fl_reg[j];
        end
    end

    // final: sin = x * ts, then swap and sign
    logic [TW-1:0]  f_tc;
    logic [TW-1:0]  f_ts;
    logic           f1_v_reg;
    logic [2*Q:0]   f1_sp_reg;
    logic [TW-1:0]  f1_tc_reg;
    sc_flags_t      f1_fl_reg;
    logic [2*Q+1:0] f2_sum;
    logic [TW-1:0]  f2_ss;
    logic [TW-1:0]  f2_s;
    logic [TW-1:0]  f2_c;

    assign f_tc = ONE - hb_pc_reg[7][Q+9 +: TW];
    assign f_ts = ONE - hb_ps_reg[7][Q+9 +: TW];
    assign f2_sum = {1'b0, f1_sp_reg} + ((2*Q+2)'(1) << (Q - 1));
    assign f2_ss  = f2_sum[Q +: TW];
    assign f2_s   = f1_fl_reg.swp ? f1_tc_reg : f2_ss;
    assign f2_c   = f1_fl_reg.swp ? f2_ss : f1_tc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg  <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            f1_v_reg  <= hb_v_reg[7];
            out_valid <= f1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f1_sp_reg <= (2*Q+1)'(hb_x_reg[7]) * (2*Q+1)'(f_ts);
        f1_tc_reg <= f_tc;
        f1_fl_reg <= hb_fl_reg[7];
        sin_v <= f1_fl_reg.sneg ? -$signed({1'b0, f2_s}) : $signed({1'b0, f2_s});
        cos_v <= f1_fl_reg.cneg ? -$signed({1'b0, f2_c}) : $signed({1'b0, f2_c});
    end

endmodule
`default_nettype wire

FILE: sv/great_circle_distance.sv
// great_circle_distance: top level of the great-circle distance pipeline.
// Depends on gcd_pkg and gcd_sincos.
//
//  channel  | ports                                  | dir | flow
//  ---------+----------------------------------------+-----+------------------------------
//  command  | start, busy, lat_a, lon_a, lat_b, lon_b | in  | beat taken on start & !busy
//  result   | done, distance_cm                      | out | one-cycle strobe, no backpressure
//  config   | cfg_valid, cfg_ready, cfg_data         | in  | radius in metres, valid & ready
//
// Flow: one beat per clock; busy stays low. The pipeline length is set by the
// Taylor Horner chain (two stages per term), the bit-per-stage square root
// (FRAC_BITS+3) and the CORDIC (FRAC_BITS+1).
// Reset clears the valid bits of every stage and loads the radius 6372795 m.
// Nothing stalls: each stage advances every clock, so no beat is dropped or repeated.
`default_nettype none
module great_circle_distance
    import gcd_pkg::*;
#(
    parameter int FRAC_BITS = 30
)
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                start,
    output logic               busy,
    input  wire  signed [30:0] lat_a,
    input  wire  signed [31:0] lon_a,
    input  wire  signed [30:0] lat_b,
    input  wire  signed [31:0] lon_b,
    output logic               done,
    output logic [32:0]        distance_cm,
    input  wire                cfg_valid,
    output logic               cfg_ready,
    input  wire  [23:0]        cfg_data
);

    localparam int Q   = FRAC_BITS;
    localparam int W   = Q + 2;      // sin/cos and product terms
    localparam int XW  = Q + 3;      // x and q terms
    localparam int VW  = 2 * Q + 6;  // sum of squares
    localparam int RSW = Q + 3;      // square root
    localparam int CW  = Q + 4;      // CORDIC vector
    localparam int ZW  = Q + 3;      // CORDIC angle
    localparam int MPW = ZW - 1 + 31;
    localparam logic [ZW-1:0] Z_HALF_PI =
        ZW'((PI_Q62 + (64'd1 << (62 - Q))) >> (63 - Q));

    // never hold off a command; the pipe takes one beat every clock
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // radius held in centimetres
    logic [30:0] rad_cm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rad_cm_reg <= RADIUS_CM_RST;
        else if (cfg_valid && cfg_ready)
            rad_cm_reg <= 31'(cfg_data) * 31'd100;
    end

    // input stage: register points and the longitude difference
    logic               in_v_reg;
    logic signed [30:0] lat_a_reg;
    logic signed [30:0] lat_b_reg;
    logic signed [32:0] dlon_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else
            in_v_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        lat_a_reg <= lat_a;
        lat_b_reg <= lat_b;
        dlon_reg  <= {lon_b[31], lon_b} - {lon_a[31], lon_a};
    end

    // three sine/cosine units run in step
    logic                va_v, vb_v, vd_v;
    logic signed [W-1:0] sa, ca, sb, cb, sd, cd;

    gcd_sincos #(.FRAC_BITS(FRAC_BITS)) u_sc_a (
        .clk(clk), .rst_n(rst_n), .in_valid(in_v_reg),
        .ang({{2{lat_a_reg[30]}}, lat_a_reg}),
        .out_valid(va_v), .sin_v(sa), .cos_v(ca)
    );

    gcd_sincos #(.FRAC_BITS(FRAC_BITS)) u_sc_b (
        .clk(clk), .rst_n(rst_n), .in_valid(in_v_reg),
        .ang({{2{lat_b_reg[30]}}, lat_b_reg}),
        .out_valid(vb_v), .sin_v(sb), .cos_v(cb)
    );

    gcd_sincos #(.FRAC_BITS(FRAC_BITS)) u_sc_d (
        .clk(clk), .rst_n(rst_n), .in_valid(in_v_reg),
        .ang(dlon_reg),
        .out_valid(vd_v), .sin_v(sd), .cos_v(cd)
    );

    function automatic logic [W-1:0] mag_w(input logic signed [W-1:0] v);
        return v[W-1] ? W'(-v) : W'(v);
    endfunction

    // round half up by 2^Q, then apply the sign
    function automatic logic signed [W-1:0] rnd_s(input logic [2*W-1:0] p, input logic neg);
        logic [2*W:0]  t;
        logic [W-1:0]  m;
        t = {1'b0, p} + ((2*W+1)'(1) << (Q - 1));
        m = t[Q +: W];
        return neg ? -$signed(m) : $signed(m);
    endfunction

    // C1: first row of products (magnitudes)
    logic             c1_v_reg;
    logic [2*W-1:0]   c1_p_reg, c1_t1_reg, c1_t2_reg, c1_t3_reg, c1_t4_reg;
    logic [4:0]       c1_neg_reg;
    logic signed [W-1:0] c1_cd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c1_v_reg <= 1'b0;
        else
            c1_v_reg <= va_v;
    end

    always_ff @(posedge clk)
    begin
        c1_p_reg   <= (2*W)'(mag_w(cb)) * (2*W)'(mag_w(sd));
        c1_t1_reg  <= (2*W)'(mag_w(ca)) * (2*W)'(mag_w(sb));
        c1_t2_reg  <= (2*W)'(mag_w(sa)) * (2*W)'(mag_w(cb));
        c1_t3_reg  <= (2*W)'(mag_w(ca)) * (2*W)'(mag_w(cb));
        c1_t4_reg  <= (2*W)'(mag_w(sa)) * (2*W)'(mag_w(sb));
        c1_neg_reg <= {cb[W-1] ^ sd[W-1], ca[W-1] ^ sb[W-1], sa[W-1] ^ cb[W-1],
                       ca[W-1] ^ cb[W-1], sa[W-1] ^ sb[W-1]};
        c1_cd_reg  <= cd;
    end

    // C2: round the first row
    logic                c2_v_reg;
    logic signed [W-1:0] c2_p_reg, c2_t1_reg, c2_t2_reg, c2_t3_reg, c2_t4_reg, c2_cd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c2_v_reg <= 1'b0;
        else
            c2_v_reg <= c1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        c2_p_reg  <= rnd_s(c1_p_reg,  c1_neg_reg[4]);
        c2_t1_reg <= rnd_s(c1_t1_reg, c1_neg_reg[3]);
        c2_t2_reg <= rnd_s(c1_t2_reg, c1_neg_reg[2]);
        c2_t3_reg <= rnd_s(c1_t3_reg, c1_neg_reg[1]);
        c2_t4_reg <= rnd_s(c1_t4_reg, c1_neg_reg[0]);
        c2_cd_reg <= c1_cd_reg;
    end

    // C3: second row of products against cos d
    logic                c3_v_reg;
    logic [2*W-1:0]      c3_r2_reg, c3_r3_reg;
    logic [1:0]          c3_neg_reg;
    logic signed [W-1:0] c3_p_reg, c3_t1_reg, c3_t4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c3_v_reg <= 1'b0;
        else
            c3_v_reg <= c2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        c3_r2_reg  <= (2*W)'(mag_w(c2_t2_reg)) * (2*W)'(mag_w(c2_cd_reg));
        c3_r3_reg  <= (2*W)'(mag_w(c2_t3_reg)) * (2*W)'(mag_w(c2_cd_reg));
        c3_neg_reg <= {c2_t2_reg[W-1] ^ c2_cd_reg[W-1], c2_t3_reg[W-1] ^ c2_cd_reg[W-1]};
        c3_p_reg   <= c2_p_reg;
        c3_t1_reg  <= c2_t1_reg;
        c3_t4_reg  <= c2_t4_reg;
    end

    // C4: q = t1 - r2, x = t4 + r3
    logic                 c4_v_reg;
    logic signed [W-1:0]  c4_r2, c4_r3;
    logic signed [W-1:0]  c4_p_reg;
    logic signed [XW-1:0] c4_q_reg, c4_x_reg;

    assign c4_r2 = rnd_s(c3_r2_reg, c3_neg_reg[1]);
    assign c4_r3 = rnd_s(c3_r3_reg, c3_neg_reg[0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c4_v_reg <= 1'b0;
        else
            c4_v_reg <= c3_v_reg;
    end

    always_ff @(posedge clk)
    begin
        c4_p_reg <= c3_p_reg;
        c4_q_reg <= XW'(c3_t1_reg) - XW'(c4_r2);
        c4_x_reg <= XW'(c3_t4_reg) + XW'(c4_r3);
    end

    // C5/C6: squares and their sum
    logic                 c5_v_reg, c6_v_reg;
    logic [VW-1:0]        c5_pp_reg, c5_qq_reg, c6_sum_reg;
    logic signed [XW-1:0] c5_x_reg, c6_x_reg;
    logic [XW-1:0]        c5_qm;

    assign c5_qm = c4_q_reg[XW-1] ? XW'(-c4_q_reg) : XW'(c4_q_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c5_v_reg <= 1'b0;
            c6_v_reg <= 1'b0;
        end
        else
        begin
            c5_v_reg <= c4_v_reg;
            c6_v_reg <= c5_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c5_pp_reg  <= VW'(mag_w(c4_p_reg)) * VW'(mag_w(c4_p_reg));
        c5_qq_reg  <= VW'(c5_qm) * VW'(c5_qm);
        c5_x_reg   <= c4_x_reg;
        c6_sum_reg <= c5_pp_reg + c5_qq_reg;
        c6_x_reg   <= c5_x_reg;
    end

    // square root: one result bit per stage, remainder form
    logic                 sq_v_reg   [0:RSW-1];
    logic [VW-1:0]        sq_rem_reg [0:RSW-1];
    logic [RSW-1:0]       sq_res_reg [0:RSW-1];
    logic signed [XW-1:0] sq_x_reg   [0:RSW-1];

    for (genvar s = 0; s < RSW; s++)
    begin : g_sqrt
        localparam int B = RSW - 1 - s;
        logic                 v_in;
        logic [VW-1:0]        rem_in;
        logic [RSW-1:0]       res_in;
        logic signed [XW-1:0] x_in;
        logic [VW-1:0]        trial;
        logic                 take;

        if (s == 0)
        begin : g_first
            assign v_in   = c6_v_reg;
            assign rem_in = c6_sum_reg;
            assign res_in = '0;
            assign x_in   = c6_x_reg;
        end
        else
        begin : g_next
            assign v_in   = sq_v_reg[s-1];
            assign rem_in = sq_rem_reg[s-1];
            assign res_in = sq_res_reg[s-1];
            assign x_in   = sq_x_reg[s-1];
        end

        assign trial = (VW'(res_in) << (B + 1)) + (VW'(1) << (2 * B));
        assign take  = trial <= rem_in;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_v_reg[s] <= 1'b0;
            else
                sq_v_reg[s] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            sq_rem_reg[s] <= take ? rem_in - trial : rem_in;
            sq_res_reg[s] <= take ? (res_in | (RSW'(1) << B)) : res_in;
            sq_x_reg[s]   <= x_in;
        end
    end

    // CORDIC entry: turn by pi/2 when x is negative
    logic                 cp_v_reg;
    logic signed [CW-1:0] cp_x_reg, cp_y_reg;
    logic signed [ZW-1:0] cp_z_reg;
    logic signed [CW-1:0] cp_xe, cp_ye;

    assign cp_xe = CW'(sq_x_reg[RSW-1]);
    assign cp_ye = $signed(CW'(sq_res_reg[RSW-1]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cp_v_reg <= 1'b0;
        else
            cp_v_reg <= sq_v_reg[RSW-1];
    end

    always_ff @(posedge clk)
    begin
        if (cp_xe < 0)
        begin
            cp_x_reg <= cp_ye;
            cp_y_reg <= -cp_xe;
            cp_z_reg <= $signed(Z_HALF_PI);
        end
        else
        begin
            cp_x_reg <= cp_xe;
            cp_y_reg <= cp_ye;
            cp_z_reg <= '0;
        end
    end

    // CORDIC vectoring, one micro-rotation per stage
    logic                 cr_v_reg [0:Q];
    logic signed [CW-1:0] cr_x_reg [0:Q];
    logic signed [CW-1:0] cr_y_reg [0:Q];
    logic signed [ZW-1:0] cr_z_reg [0:Q];

    for (genvar i = 0; i <= Q; i++)
    begin : g_cordic
        localparam logic [63:0] AT_Q62 = (i == 0) ? ((PI_Q62 + 64'd2) >> 2) : atan_q62(i);
        localparam logic [ZW-1:0] AT = ZW'((AT_Q62 + (64'd1 << (61 - Q))) >> (62 - Q));
        logic                 v_in;
        logic signed [CW-1:0] x_in, y_in, dx, dy;
        logic signed [ZW-1:0] z_in;

        if (i == 0)
        begin : g_first
            assign v_in = cp_v_reg;
            assign x_in = cp_x_reg;
            assign y_in = cp_y_reg;
            assign z_in = cp_z_reg;
        end
        else
        begin : g_next
            assign v_in = cr_v_reg[i-1];
            assign x_in = cr_x_reg[i-1];
            assign y_in = cr_y_reg[i-1];
            assign z_in = cr_z_reg[i-1];
        end

        assign dx = y_in >>> i;
        assign dy = x_in >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cr_v_reg[i] <= 1'b0;
            else
                cr_v_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (y_in > 0)
            begin
                cr_x_reg[i] <= x_in + dx;
                cr_y_reg[i] <= y_in - dy;
                cr_z_reg[i] <= z_in + $signed(AT);
            end
            else if (y_in < 0)
            begin
                cr_x_reg[i] <= x_in - dx;
                cr_y_reg[i] <= y_in + dy;
                cr_z_reg[i] <= z_in - $signed(AT);
            end
            else
            begin
                cr_x_reg[i] <= x_in;
                cr_y_reg[i] <= y_in;
                cr_z_reg[i] <= z_in;
            end
        end
    end

    // clamp the angle at zero and scale by the radius
    logic            mp_v_reg;
    logic [MPW-1:0]  mp_reg;
    logic [ZW-2:0]   z_clamp;
    logic [MPW:0]    out_sum;

    assign z_clamp = cr_z_reg[Q][ZW-1] ? '0 : cr_z_reg[Q][ZW-2:0];
    assign out_sum = {1'b0, mp_reg} + ((MPW+1)'(1) << (Q - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mp_v_reg <= 1'b0;
            done     <= 1'b0;
        end
        else
        begin
            mp_v_reg <= cr_v_reg[Q];
            done     <= mp_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mp_reg      <= MPW'(z_clamp) * MPW'(rad_cm_reg);
        distance_cm <= out_sum[Q +: 33];
    end

    // the three sine/cosine units must stay in lock step
    assert property (@(posedge clk) disable iff (!rst_n)
        (va_v == vb_v) && (va_v == vd_v))
        else $error("sine/cosine units out of step");

    // the square root leaves a remainder no larger than twice the root
    assert property (@(posedge clk) disable iff (!rst_n)
        sq_v_reg[RSW-1] |-> (sq_rem_reg[RSW-1] <= (VW'(sq_res_reg[RSW-1]) << 1)))
        else $error("square root remainder out of range");

    // a config beat loads the radius scaled to centimetres
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> (rad_cm_reg == 31'($past(cfg_data)) * 31'd100))
        else $error("radius register not loaded");

endmodule
`default_nettype wire

FILE: tb/sv/great_circle_distance_checker.sv
// Checker for great_circle_distance: computes the expected distance for each
// accepted command beat and compares it with the result strobes.
// Depends on nothing beyond the block's port list.
`timescale 1ns / 100ps
`default_nettype none
module great_circle_distance_checker
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    input  wire         busy,
    input  wire  [30:0] lat_a,
    input  wire  [31:0] lon_a,
    input  wire  [30:0] lat_b,
    input  wire  [31:0] lon_b,
    input  wire         done,
    input  wire  [32:0] distance_cm,
    input  wire         cfg_valid,
    input  wire         cfg_ready,
    input  wire  [23:0] cfg_data,
    output int          errors,
    output int          pending
);

    localparam int          Q       = 30;
    localparam logic [63:0] UNIT    = 64'd1 << Q;
    localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C235;
    localparam longint      FULL    = 64'sd3600000000;
    localparam longint      HALF    = 64'sd1800000000;
    localparam longint      QUARTER = 64'sd900000000;
    localparam longint      EIGHTH  = 64'sd450000000;
    localparam logic [63:0] HALF_U  = 64'd1800000000;
    localparam logic [63:0] DEG_K   = ((PI_Q62 / HALF_U) << 31)
        + ((((PI_Q62 % HALF_U) << 31) + HALF_U / 2) / HALF_U);
    localparam logic [23:0] RADIUS_RST = 24'd6372795;

    logic [23:0] radius_m;
    logic [32:0] dist_q[$];

    function automatic logic [63:0] absv(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // Q product, rounded half away from zero via magnitudes
    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return 64'((p + (128'd1 << (Q - 1))) >> Q);
    endfunction

    function automatic longint qmuls(input longint a, input longint b);
        longint r;
        r = longint'(qmul(absv(a), absv(b)));
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic logic [63:0] rad_of(input logic [63:0] m);
        logic [127:0] p;
        p = {64'd0, m} * {64'd0, DEG_K};
        return 64'((p + (128'd1 << (92 - Q))) >> (93 - Q));
    endfunction

    task automatic series(input logic [63:0] x, output logic [63:0] s, output logic [63:0] c);
        logic [63:0] x2, ts, tc, d;
        x2 = qmul(x, x);
        ts = UNIT;
        tc = UNIT;
        for (int k = 8; k > 0; k--)
        begin
            d  = 64'((2 * k - 1) * (2 * k));
            tc = UNIT - (qmul(x2, tc) + d / 2) / d;
        end
        for (int k = 7; k > 0; k--)
        begin
            d  = 64'((2 * k) * (2 * k + 1));
            ts = UNIT - (qmul(x2, ts) + d / 2) / d;
        end
        s = qmul(x, ts);
        c = tc;
    endtask

    // fold the angle to the first octant, then restore signs
    task automatic trig(input longint a, output longint s, output longint c);
        longint      r;
        logic        sneg, cneg;
        logic [63:0] m, ss, cc;
        r = a % FULL;
        if (r >= HALF)
            r -= FULL;
        if (r < -HALF)
            r += FULL;
        sneg = r < 0;
        m    = absv(r);
        cneg = 1'b0;
        if (m > 64'(QUARTER))
        begin
            m    = 64'(HALF) - m;
            cneg = 1'b1;
        end
        if (m > 64'(EIGHTH))
            series(rad_of(64'(QUARTER) - m), cc, ss);
        else
            series(rad_of(m), ss, cc);
        s = sneg ? -longint'(ss) : longint'(ss);
        c = cneg ? -longint'(cc) : longint'(cc);
    endtask

    function automatic logic [63:0] root(input logic [127:0] v);
        logic [63:0] res, cand;
        res = 64'd0;
        for (int b = Q + 2; b >= 0; b--)
        begin
            cand = res | (64'd1 << b);
            if ({64'd0, cand} * {64'd0, cand} <= v)
                res = cand;
        end
        return res;
    endfunction

    // vectoring rotation, y >= 0, angle in Q radians
    function automatic logic [63:0] arc(input longint y_in, input longint x_in);
        longint      at[Q+1];
        longint      y, x, z, t, dx, dy;
        logic [63:0] pos, neg, term;
        y = y_in;
        x = x_in;
        z = 0;
        at[0] = longint'((((PI_Q62 + 64'd2) >> 2) + (64'd1 << (61 - Q))) >> (62 - Q));
        for (int i = 1; i <= Q; i++)
        begin
            pos = 64'd0;
            neg = 64'd0;
            for (int k = 0; i * (2 * k + 1) <= 62; k++)
            begin
                term = (64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1);
                if (k % 2 == 1)
                    neg += term;
                else
                    pos += term;
            end
            at[i] = longint'(((pos - neg) + (64'd1 << (61 - Q))) >> (62 - Q));
        end
        if (x < 0)
        begin
            t = x;
            x = y;
            y = -t;
            z = longint'((PI_Q62 + (64'd1 << (62 - Q))) >> (63 - Q));
        end
        for (int i = 0; i <= Q; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x += dx;
                y -= dy;
                z += at[i];
            end
            else if (y < 0)
            begin
                x -= dx;
                y += dy;
                z -= at[i];
            end
        end
        return z < 0 ? 64'd0 : 64'(z);
    endfunction

    task automatic predict_distance(input logic signed [30:0] la, input logic signed [31:0] oa,
                                    input logic signed [30:0] lb, input logic signed [31:0] ob,
                                    input logic [23:0] rad, output logic [32:0] dist_cm);
        longint       sa, ca, sb, cb, sd, cd, p, q, x, lon_d;
        logic [127:0] sq, prod;
        logic [63:0]  y, z;
        lon_d = longint'(ob) - longint'(oa);
        trig(longint'(la), sa, ca);
        trig(longint'(lb), sb, cb);
        trig(lon_d, sd, cd);
        p  = qmuls(cb, sd);
        q  = qmuls(ca, sb) - qmuls(qmuls(sa, cb), cd);
        x  = qmuls(sa, sb) + qmuls(qmuls(ca, cb), cd);
        sq = {64'd0, absv(p)} * {64'd0, absv(p)} + {64'd0, absv(q)} * {64'd0, absv(q)};
        y  = root(sq);
        z  = arc(longint'(y), x);
        prod = {64'd0, z} * {64'd0, 64'(rad) * 64'd100};
        dist_cm = 33'((prod + (128'd1 << (Q - 1))) >> Q);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [32:0] want;
        if (!rst_n)
        begin
            radius_m = RADIUS_RST;
            dist_q.delete();
            errors   = 0;
        end
        else
        begin
            if (done)
            begin
                if (dist_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result beat, expected none, actual %0d",
                             $realtime, distance_cm);
                end
                else
                begin
                    want = dist_q.pop_front();
                    if (want !== distance_cm)
                    begin
                        errors++;
                        $display("%0t: distance_cm expected %0d, actual %0d",
                                 $realtime, want, distance_cm);
                    end
                end
            end
            if (start && !busy)
            begin
                predict_distance(lat_a, lon_a, lat_b, lon_b, radius_m, want);
                dist_q.push_back(want);
            end
            if (cfg_valid && cfg_ready)
                radius_m = cfg_data;
        end
        pending = dist_q.size();
    end

endmodule
`default_nettype wire

FILE: tb/sv/great_circle_distance_tb.sv
// Testbench top for great_circle_distance: drives point pairs and radius
// writes, and gives the verdict. Depends on great_circle_distance and
// great_circle_distance_checker.
`timescale 1ns / 100ps
`default_nettype none
module great_circle_distance_tb;

    localparam int LATENCY    = 98;
    localparam int IDLE_LIMIT = 4000;
    localparam int PER_PHASE  = 130;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [30:0] lat_a;
    logic signed [31:0] lon_a;
    logic signed [30:0] lat_b;
    logic signed [31:0] lon_b;
    logic               done;
    logic [32:0]        distance_cm;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [23:0]        cfg_data;
    int                 errors;
    int                 pending;
    int                 quiet_cycles;

    great_circle_distance u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .lat_a       (lat_a),
        .lon_a       (lon_a),
        .lat_b       (lat_b),
        .lon_b       (lon_b),
        .done        (done),
        .distance_cm (distance_cm),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    // The checker sees the same ports; it owns the prediction and the compare.
    great_circle_distance_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .lat_a       (lat_a),
        .lon_a       (lon_a),
        .lat_b       (lat_b),
        .lon_b       (lon_b),
        .done        (done),
        .distance_cm (distance_cm),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .pending     (pending)
    );

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: count clocks in which no beat moves on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == IDLE_LIMIT)
        begin
            $display("great_circle_distance: mismatch");
            $finish;
        end
    end

    // Present one pair at the falling edge and hold it until a rising edge
    // takes it with busy low. start stays high so back-to-back beats need
    // no second assignment in the same step.
    task automatic send_pair(input logic [30:0] la, input logic [31:0] oa,
                             input logic [30:0] lb, input logic [31:0] ob);
        @(negedge clk);
        start = 1'b1;
        lat_a = la;
        lon_a = oa;
        lat_b = lb;
        lon_b = ob;
        while (busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Drop start for a random idle burst.
    task automatic idle_burst();
        int n;
        n = $urandom_range(1, 3);
        @(negedge clk);
        start = 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // Hold off until every expected distance has come, then let the pipe empty.
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    task automatic write_radius(input logic [23:0] r);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = r;
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Mostly points on the globe; some raw bit patterns; some near-coincident
    // and near-antipodal pairs, where the angle is least well conditioned.
    task automatic random_pair(input bit allow_idle);
        logic [30:0] la, lb;
        logic [31:0] oa, ob;
        int          kind;
        kind = $urandom_range(0, 9);
        la = 31'(longint'($urandom_range(0, 1800000000)) - 64'sd900000000);
        lb = 31'(longint'($urandom_range(0, 1800000000)) - 64'sd900000000);
        oa = 32'(longint'($urandom_range(0, 32'd3600000000)) - 64'sd1800000000);
        ob = 32'(longint'($urandom_range(0, 32'd3600000000)) - 64'sd1800000000);
        if (kind == 7 || kind == 8)
        begin
            la = 31'($urandom());
            lb = 31'($urandom());
            oa = $urandom();
            ob = $urandom();
        end
        else if (kind == 9)
        begin
            lb = la + 31'($urandom_range(0, 2000)) - 31'd1000;
            ob = oa + 32'($urandom_range(0, 2000)) - 32'd1000;
            if ($urandom_range(0, 1))
            begin
                lb = -lb;
                ob = ob + 32'd1800000000;
            end
        end
        if (allow_idle && $urandom_range(0, 4) == 0)
            idle_burst();
        send_pair(la, oa, lb, ob);
    endtask

    initial
    begin
        logic [23:0] radii[5];
        rst_n     = 1'b0;
        start     = 1'b0;
        lat_a     = '0;
        lon_a     = '0;
        lat_b     = '0;
        lon_b     = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed pairs at the reset radius.
        send_pair(31'sd0, 32'sd0, 31'sd0, 32'sd0);
        send_pair(31'sd0, 32'sd0, 31'sd0, 32'sd1800000000);
        send_pair(31'sd900000000, 32'sd0, -31'sd900000000, 32'sd0);
        send_pair(31'sd900000000, 32'sd123, 31'sd900000000, -32'sd456);
        send_pair(-31'sd900000000, 32'sd0, 31'sd0, 32'sd0);
        send_pair(31'sd0, -32'sd1800000000, 31'sd0, 32'sd1800000000);
        send_pair(31'sd0, 32'sd0, 31'sd0, 32'sd1);
        send_pair(31'sd0, 32'sd0, 31'sd10, 32'sd0);
        // latitudes past the pole and longitudes at the bit limits
        send_pair(31'sd1073741823, 32'sd2147483647, -31'sd1073741824, -32'sd2147483648);
        send_pair(-31'sd1073741824, -32'sd2147483648, 31'sd1073741823, 32'sd2147483647);
        send_pair(31'sd450000000, 32'sd100000000, -31'sd450000000, -32'sd800000000);
        send_pair(31'sd0, 32'sd0, 31'sd0, 32'sd900000000);
        // mostly negative x: more than a quarter turn apart
        send_pair(31'sd300000000, 32'sd0, -31'sd300000000, 32'sd1790000000);
        send_pair(31'sd0, 32'sd450000000, 31'sd0, -32'sd450000001);
        send_pair(31'sd450000000, 32'sd0, 31'sd450000001, 32'sd0);
        send_pair(-31'sd899999999, 32'sd1799999999, 31'sd899999999, -32'sd1799999999);

        radii[0] = 24'd1;
        radii[1] = 24'd0;
        radii[2] = 24'd16777215;
        radii[3] = 24'($urandom_range(1, 16777215));
        radii[4] = 24'd6372795;

        for (int i = 0; i < PER_PHASE; i++)
            random_pair(1'b1);

        for (int ph = 0; ph < 5; ph++)
        begin
            drain();
            write_radius(radii[ph]);
            for (int i = 0; i < PER_PHASE; i++)
            begin
                // one pause in the middle of the run until the pipe is empty
                if (ph == 1 && i == PER_PHASE / 2)
                    drain();
                random_pair(ph != 4);
            end
        end

        @(negedge clk);
        start = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);

        if (errors == 0)
            $display("great_circle_distance: match");
        else
            $display("great_circle_distance: mismatch");
        $finish;
    end

endmodule
`default_nettype wire
